[rtl/core/pairing_function_pack_unpack_core_assert.svh]
// Assertion macros for the pairing function pack/unpack core.
// Included by the top level only; no other dependencies.
`ifndef PAIRING_FUNCTION_PACK_UNPACK_CORE_ASSERT_SVH
`define PAIRING_FUNCTION_PACK_UNPACK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PFPU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pfpu implication check failed");
`define PFPU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pfpu next-cycle check failed");
`else
`define PFPU_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PFPU_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[rtl/core/pfpu_pkg.sv]
// Shared types and constants for the pairing function pack/unpack core.
// No dependencies.
package pfpu_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned REM_W   = VAL_W + 1;
  localparam int unsigned CELLS   = KEY_W / 2;
  localparam int unsigned LATENCY = CELLS + 2;

  localparam logic KIND_PACK   = 1'b0;
  localparam logic KIND_UNPACK = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [REM_W-1:0] rem;
    logic [VAL_W-1:0] root;
  } stage_t;

endpackage

[rtl/core/pfpu_front.sv]
// Input stage: registers an item and squares the larger pack operand.
// Depends on pfpu_pkg.
module pfpu_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic                        kind,
  input  logic [pfpu_pkg::VAL_W-1:0]  first_value,
  input  logic [pfpu_pkg::VAL_W-1:0]  second_value,
  input  logic [pfpu_pkg::KEY_W-1:0]  packed_key,
  output pfpu_pkg::stage_t            stage_out
);

  logic                        valid_r;
  logic                        kind_r;
  logic [pfpu_pkg::KEY_W-1:0]  prod_r;
  logic [pfpu_pkg::VAL_W:0]    addend_r;
  logic [pfpu_pkg::KEY_W-1:0]  key_r;
  logic                        a_ge_b;
  logic [pfpu_pkg::VAL_W-1:0]  larger;
  logic [pfpu_pkg::VAL_W:0]    addend_nxt;

  always_comb begin
    a_ge_b = (first_value >= second_value);
    larger = a_ge_b ? first_value : second_value;
    if (a_ge_b) begin
      addend_nxt = {1'b0, first_value} + {1'b0, second_value};
    end else begin
      addend_nxt = {1'b0, first_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
    kind_r   <= kind;
    prod_r   <= {{pfpu_pkg::VAL_W{1'b0}}, larger} * {{pfpu_pkg::VAL_W{1'b0}}, larger};
    addend_r <= addend_nxt;
    key_r    <= packed_key;
  end

  always_comb begin
    stage_out.valid = valid_r;
    stage_out.kind  = kind_r;
    if (kind_r == pfpu_pkg::KIND_UNPACK) begin
      stage_out.key = key_r;
    end else begin
      stage_out.key = prod_r + {{(pfpu_pkg::KEY_W - pfpu_pkg::VAL_W - 1){1'b0}}, addend_r};
    end
    stage_out.rem  = '0;
    stage_out.root = '0;
  end

endmodule

[rtl/core/pfpu_cell.sv]
// One square root cell: settles one root bit from the next two key bits of an unpack item; pack items pass through.
// Depends on pfpu_pkg.
module pfpu_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  pfpu_pkg::stage_t stage_in,
  output pfpu_pkg::stage_t stage_out
);

  pfpu_pkg::stage_t            stage_r;
  pfpu_pkg::stage_t            stage_nxt;
  logic [pfpu_pkg::REM_W+1:0]  rem_sh;
  logic [pfpu_pkg::REM_W+1:0]  trial;
  logic [pfpu_pkg::REM_W+1:0]  diff;

  always_comb begin
    rem_sh    = {stage_in.rem, stage_in.key[pfpu_pkg::KEY_W-1 -: 2]};
    trial     = {1'b0, stage_in.root, 2'b01};
    diff      = rem_sh - trial;
    stage_nxt = stage_in;
    if (stage_in.kind == pfpu_pkg::KIND_UNPACK) begin
      stage_nxt.key = {stage_in.key[pfpu_pkg::KEY_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        stage_nxt.rem  = diff[pfpu_pkg::REM_W-1:0];
        stage_nxt.root = {stage_in.root[pfpu_pkg::VAL_W-2:0], 1'b1};
      end else begin
        stage_nxt.rem  = rem_sh[pfpu_pkg::REM_W-1:0];
        stage_nxt.root = {stage_in.root[pfpu_pkg::VAL_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '{valid: 1'b0,
                   kind:  stage_nxt.kind,
                   key:   stage_nxt.key,
                   rem:   stage_nxt.rem,
                   root:  stage_nxt.root};
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

[rtl/core/pfpu_tail.sv]
// Output stage: splits root and remainder into the value pair and drives results.
// Depends on pfpu_pkg.
module pfpu_tail (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfpu_pkg::stage_t           stage_in,
  output logic                       out_valid,
  output logic [pfpu_pkg::KEY_W-1:0] out_key,
  output logic [pfpu_pkg::VAL_W-1:0] out_first,
  output logic [pfpu_pkg::VAL_W-1:0] out_second
);

  logic                       valid_r;
  logic [pfpu_pkg::KEY_W-1:0] key_r,    key_nxt;
  logic [pfpu_pkg::VAL_W-1:0] first_r,  first_nxt;
  logic [pfpu_pkg::VAL_W-1:0] second_r, second_nxt;
  logic [pfpu_pkg::REM_W-1:0] root_ext;
  logic [pfpu_pkg::REM_W-1:0] excess;

  always_comb begin
    root_ext   = {1'b0, stage_in.root};
    excess     = stage_in.rem - root_ext;
    key_nxt    = '0;
    first_nxt  = '0;
    second_nxt = '0;
    if (stage_in.kind == pfpu_pkg::KIND_UNPACK) begin
      if (stage_in.rem >= root_ext) begin
        first_nxt  = stage_in.root;
        second_nxt = excess[pfpu_pkg::VAL_W-1:0];
      end else begin
        first_nxt  = stage_in.rem[pfpu_pkg::VAL_W-1:0];
        second_nxt = stage_in.root;
      end
    end else begin
      key_nxt = stage_in.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_in.valid;
    end
    key_r    <= key_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

  assign out_valid  = valid_r;
  assign out_key    = key_r;
  assign out_first  = first_r;
  assign out_second = second_r;

endmodule

[rtl/core/pairing_function_pack_unpack_core.sv]
// Top level of the pairing function pack/unpack core.
// Depends on pfpu_pkg, pfpu_front, pfpu_cell, pfpu_tail and the assertion header.
//
//   Channel   Handshake         Payload
//   input     start / busy      in_kind, in_first_value, in_second_value, in_packed_key
//   result    out_valid strobe  out_key_out, out_first_out, out_second_out
//
// One item is accepted every cycle; busy is always low.
// Each item passes through one squaring stage, 32 square root cells
// of one root bit each, and one output stage.
// Reset is synchronous and clears only the valid bits along the chain.
// The receiver cannot stall, so nothing ever backs up.
`include "pairing_function_pack_unpack_core_assert.svh"

module pairing_function_pack_unpack_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_first_value,
  input  logic [31:0] in_second_value,
  input  logic [63:0] in_packed_key,
  output logic        out_valid,
  output logic [63:0] out_key_out,
  output logic [31:0] out_first_out,
  output logic [31:0] out_second_out
);

  pfpu_pkg::stage_t chain [0:pfpu_pkg::CELLS];
  pfpu_pkg::stage_t chain_end;
  logic             take;
  logic             end_unpack;
  logic             out_one_kind;

  assign busy = 1'b0;
  assign take = start && !busy;

  pfpu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .kind         (in_kind),
    .first_value  (in_first_value),
    .second_value (in_second_value),
    .packed_key   (in_packed_key),
    .stage_out    (chain[0])
  );

  for (genvar i = 0; i < pfpu_pkg::CELLS; i++) begin : g_cell
    pfpu_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  pfpu_tail u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_in   (chain[pfpu_pkg::CELLS]),
    .out_valid  (out_valid),
    .out_key    (out_key_out),
    .out_first  (out_first_out),
    .out_second (out_second_out)
  );

  assign chain_end    = chain[pfpu_pkg::CELLS];
  assign end_unpack   = chain_end.valid && (chain_end.kind == pfpu_pkg::KIND_UNPACK);
  assign out_one_kind = (out_key_out == 64'd0) ||
                        ((out_first_out == 32'd0) && (out_second_out == 32'd0));

  `PFPU_ASSERT_IMP(a_result_has_item, clk, rst_n, out_valid, $past(take, pfpu_pkg::LATENCY))
  `PFPU_ASSERT_NEXT(a_item_enters, clk, rst_n, take, chain[0].valid)
  `PFPU_ASSERT_IMP(a_rem_bound, clk, rst_n, end_unpack, chain_end.rem <= {chain_end.root, 1'b0})
  `PFPU_ASSERT_IMP(a_one_kind_out, clk, rst_n, out_valid, out_one_kind)

endmodule
